// ===== rtl/core/bbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared constants for the blackbody temperature to RGB pipeline.
// ----------------------------------------------------------------------------
package bbt_pkg;

    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int OUT_W             = 18;
    localparam int TEMP_W            = 16;
    localparam int TC_W              = 14;   // clamped temperature, <= 15000
    localparam int TT_W              = 28;   // its square
    localparam int UV_FRAC           = 32;
    localparam int POLY_W            = 61;   // u,v numerators and denominators
    localparam int ABC_W             = 36;   // 3u, 2v, 4-u-10v in Q.32
    localparam int MAG_W             = 62;   // |r|,|g|,|b| magnitude
    localparam int S_DATA_W          = 16;
    localparam int M_DATA_W          = 56;

    localparam logic [TEMP_W-1:0] T_MIN = 16'd1000;
    localparam logic [TEMP_W-1:0] T_MAX = 16'd15000;

    // Krystek coefficients scaled by 1e16
    localparam logic [POLY_W-1:0] C_NU0 = 61'd8601177570000000;
    localparam logic [POLY_W-1:0] C_NU1 = 61'd1541182540000;
    localparam logic [POLY_W-1:0] C_NU2 = 61'd1286412120;
    localparam logic [POLY_W-1:0] C_DU0 = 61'd10000000000000000;
    localparam logic [POLY_W-1:0] C_DU1 = 61'd8424202350000;
    localparam logic [POLY_W-1:0] C_DU2 = 61'd7081451630;
    localparam logic [POLY_W-1:0] C_NV0 = 61'd3173987260000000;
    localparam logic [POLY_W-1:0] C_NV1 = 61'd422806245000;
    localparam logic [POLY_W-1:0] C_NV2 = 61'd420481691;
    localparam logic [POLY_W-1:0] C_DV0 = 61'd10000000000000000;
    localparam logic [POLY_W-1:0] C_DV1 = 61'd289741816000;
    localparam logic [POLY_W-1:0] C_DV2 = 61'd1614560530;

    // XYZ to linear sRGB, scaled by 1e7, row major
    localparam int MTX_W = 26;
    localparam logic signed [MTX_W-1:0] MTX [9] = '{
        26'sd32404542, -26'sd15371385, -26'sd4985314,
        -26'sd9692660, 26'sd18760108,  26'sd415560,
        26'sd556434,   -26'sd2040259,  26'sd10572252
    };

    typedef struct packed {
        logic       zero;      // largest component not positive
        logic [2:0] neg;       // sign of b, g, r
        logic       clamped;
    } bbt_side_t;

endpackage

// ===== rtl/core/bbt_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_poly
// Clamp and Krystek numerator/denominator polynomials, three stages.
// ----------------------------------------------------------------------------
module bbt_poly import bbt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [TEMP_W-1:0] temp_k,
    output logic              out_valid,
    output logic [POLY_W-1:0] nu,
    output logic [POLY_W-1:0] du,
    output logic [POLY_W-1:0] nv,
    output logic [POLY_W-1:0] dv,
    output logic              clamped
);

    logic [2:0]        vld_reg;
    logic [TC_W-1:0]   t_reg,  t_next;
    logic [TT_W-1:0]   tt_reg, tt_next;
    logic [2:0]        clp_reg;
    logic              clp_next;
    logic [POLY_W-1:0] p_reg [6];
    logic [POLY_W-1:0] p_next [6];
    logic [POLY_W-1:0] nu_reg, du_reg, nv_reg, dv_reg;

    always_comb begin
        logic [TEMP_W-1:0] tc;
        tc       = temp_k;
        clp_next = 1'b0;
        if (temp_k < T_MIN) begin
            tc       = T_MIN;
            clp_next = 1'b1;
        end else if (temp_k > T_MAX) begin
            tc       = T_MAX;
            clp_next = 1'b1;
        end
        t_next  = tc[TC_W-1:0];
        tt_next = TT_W'(tc[TC_W-1:0]) * TT_W'(tc[TC_W-1:0]);
    end

    always_comb begin
        p_next[0] = POLY_W'(C_NU1 * POLY_W'(t_reg));
        p_next[1] = POLY_W'(C_NU2 * POLY_W'(tt_reg));
        p_next[2] = POLY_W'(C_DU1 * POLY_W'(t_reg));
        p_next[3] = POLY_W'(C_DU2 * POLY_W'(tt_reg));
        p_next[4] = POLY_W'(C_NV1 * POLY_W'(t_reg));
        p_next[5] = POLY_W'(C_NV2 * POLY_W'(tt_reg));
    end

    // dv keeps its own products: its linear term is subtracted
    logic [POLY_W-1:0] pdv1_reg, pdv2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg    <= t_next;
            tt_reg   <= tt_next;
            clp_reg  <= {clp_reg[1:0], clp_next};
            for (int k = 0; k < 6; k++) begin
                p_reg[k] <= p_next[k];
            end
            pdv1_reg <= POLY_W'(C_DV1 * POLY_W'(t_reg));
            pdv2_reg <= POLY_W'(C_DV2 * POLY_W'(tt_reg));
            nu_reg   <= C_NU0 + p_reg[0] + p_reg[1];
            du_reg   <= C_DU0 + p_reg[2] + p_reg[3];
            nv_reg   <= C_NV0 + p_reg[4] + p_reg[5];
            dv_reg   <= C_DV0 + pdv2_reg - pdv1_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign nu        = nu_reg;
    assign du        = du_reg;
    assign nv        = nv_reg;
    assign dv        = dv_reg;
    assign clamped   = clp_reg[2];

endmodule

// ===== rtl/core/bbt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_div
// Pipelined restoring fraction divider, one quotient bit per stage.
// Quotient saturates to all ones when num >= den.
// ----------------------------------------------------------------------------
module bbt_div import bbt_pkg::*; #(
    parameter int W      = POLY_W,
    parameter int QB     = UV_FRAC,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ce,
    input  logic                       in_valid,
    input  logic [LANES-1:0][W-1:0]    num,
    input  logic [LANES-1:0][W-1:0]    den,
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       out_valid,
    output logic [LANES-1:0][QB-1:0]   quo,
    output logic [SIDE_W-1:0]          side_out
);

    logic [QB-1:0]                vld_reg;
    logic [LANES-1:0][W-1:0]      rem_reg  [QB];
    logic [LANES-1:0][W-1:0]      den_reg  [QB];
    logic [LANES-1:0][QB-1:0]     q_reg    [QB];
    logic [LANES-1:0]             sat_reg  [QB];
    logic [SIDE_W-1:0]            side_reg [QB];

    logic [LANES-1:0][W-1:0]      rem_src  [QB];
    logic [LANES-1:0][W-1:0]      den_src  [QB];
    logic [LANES-1:0][QB-1:0]     q_src    [QB];
    logic [LANES-1:0]             sat_src  [QB];
    logic [LANES-1:0][W-1:0]      rem_next [QB];
    logic [LANES-1:0][QB-1:0]     q_next   [QB];

    always_comb begin
        for (int i = 0; i < QB; i++) begin
            if (i == 0) begin
                for (int l = 0; l < LANES; l++) begin
                    sat_src[i][l] = (num[l] >= den[l]);
                    rem_src[i][l] = sat_src[i][l] ? '0 : num[l];
                end
                den_src[i] = den;
                q_src[i]   = '0;
            end else begin
                sat_src[i] = sat_reg[i-1];
                rem_src[i] = rem_reg[i-1];
                den_src[i] = den_reg[i-1];
                q_src[i]   = q_reg[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < QB; i++) begin
            for (int l = 0; l < LANES; l++) begin
                logic [W:0] sh;
                logic       ge;
                sh = {rem_src[i][l], 1'b0};
                ge = (sh >= {1'b0, den_src[i][l]});
                rem_next[i][l] = ge ? W'(sh - {1'b0, den_src[i][l]}) : W'(sh);
                q_next[i][l]   = {q_src[i][l][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[QB-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < QB; i++) begin
                rem_reg[i]  <= rem_next[i];
                q_reg[i]    <= q_next[i];
                den_reg[i]  <= den_src[i];
                sat_reg[i]  <= sat_src[i];
                side_reg[i] <= (i == 0) ? side_in : side_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quo[l] = sat_reg[QB-1][l] ? '1 : q_reg[QB-1][l];
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign side_out  = side_reg[QB-1];

endmodule

// ===== rtl/core/bbt_mtx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbt_mtx
// u,v to scaled XYZ, sRGB matrix, then largest component and magnitudes.
// ----------------------------------------------------------------------------
module bbt_mtx import bbt_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [UV_FRAC-1:0]          u,
    input  logic [UV_FRAC-1:0]          v,
    input  logic                        clamped,
    output logic                        out_valid,
    output logic [2:0][MAG_W-1:0]       mag,
    output logic [MAG_W-1:0]            max_mag,
    output logic signed [63:0]          max_val,
    output bbt_side_t                   side
);

    logic [3:0]               vld_reg;
    logic [3:0]               clp_reg;
    logic signed [ABC_W-1:0]  abc_reg  [3];
    logic signed [ABC_W-1:0]  abc_next [3];
    logic signed [63:0]       p_reg    [9];
    logic signed [63:0]       s_reg    [3];
    logic [2:0][MAG_W-1:0]    mag_reg,  mag_next;
    logic [MAG_W-1:0]         mx_reg,   mx_next;
    logic signed [63:0]       mv_reg,   mv_next;
    logic [2:0]               neg_reg,  neg_next;
    logic                     zero_reg, zero_next;

    always_comb begin
        abc_next[0] = signed'(ABC_W'(u) + (ABC_W'(u) << 1));
        abc_next[1] = signed'(ABC_W'(v) << 1);
        abc_next[2] = signed'((ABC_W'(1) << (UV_FRAC + 2)) - ABC_W'(u)
                              - (ABC_W'(v) << 3) - (ABC_W'(v) << 1));
    end

    always_comb begin
        logic signed [63:0] m;
        m = s_reg[0];
        if (s_reg[1] > m) begin
            m = s_reg[1];
        end
        if (s_reg[2] > m) begin
            m = s_reg[2];
        end
        mv_next   = m;
        zero_next = (m <= 64'sd0);
        // den of one keeps the divider defined; the result is forced to zero
        mx_next   = zero_next ? MAG_W'(1) : MAG_W'(m);
        for (int j = 0; j < 3; j++) begin
            neg_next[j] = s_reg[j][63];
            mag_next[j] = neg_next[j] ? MAG_W'(-s_reg[j]) : MAG_W'(s_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            clp_reg <= {clp_reg[2:0], clamped};
            for (int k = 0; k < 3; k++) begin
                abc_reg[k] <= abc_next[k];
            end
            for (int k = 0; k < 9; k++) begin
                p_reg[k] <= 64'(MTX[k]) * 64'(abc_reg[k % 3]);
            end
            for (int j = 0; j < 3; j++) begin
                s_reg[j] <= p_reg[3*j] + p_reg[3*j+1] + p_reg[3*j+2];
            end
            mag_reg  <= mag_next;
            mx_reg   <= mx_next;
            mv_reg   <= mv_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
        end
    end

    assign out_valid    = vld_reg[3];
    assign mag          = mag_reg;
    assign max_mag      = mx_reg;
    assign max_val      = mv_reg;
    assign side.zero    = zero_reg;
    assign side.neg     = neg_reg;
    assign side.clamped = clp_reg[3];

endmodule

// ===== rtl/core/blackbody_temperature_to_rgb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blackbody_temperature_to_rgb_top
// Color temperature in kelvin to normalized linear sRGB.
// ----------------------------------------------------------------------------
// Takes one 16-bit temperature per beat and returns red, green and blue
// divided by the largest of the three, signed with OUT_FRAC_BITS fraction
// bits, plus a flag set when the input lay outside 1000..15000 K and was
// clamped. One beat is accepted every clock while s_axis_tready is high. A
// beat passes the polynomial stages, the u,v chromaticity divider, the matrix
// stages, the normalization divider and an output register, both dividers
// working one bit per stage. The whole pipeline holds while a result waits on
// m_axis_tready; s_axis_tready drops only then.
// ----------------------------------------------------------------------------
module blackbody_temperature_to_rgb_top import bbt_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [15:0] temperature_k
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // [17:0] red, [35:18] green,
                                                // [53:36] blue, [55:54] zero
    output logic                m_axis_tuser    // [0] clamped
);

    localparam int QN = OUT_FRAC_BITS + 1;
    localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(64'(1) << OUT_FRAC_BITS);

    // global advance: every stage moves unless a result is stuck at the output
    logic ce;
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    // polynomials
    logic              poly_vld, poly_clp;
    logic [POLY_W-1:0] nu, du, nv, dv;

    bbt_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .temp_k    (s_axis_tdata[TEMP_W-1:0]),
        .out_valid (poly_vld),
        .nu        (nu),
        .du        (du),
        .nv        (nv),
        .dv        (dv),
        .clamped   (poly_clp)
    );

    // u = nu/du, v = nv/dv in Q0.32
    logic                       uv_vld, uv_clp;
    logic [1:0][UV_FRAC-1:0]    uv;

    bbt_div #(
        .W      (POLY_W),
        .QB     (UV_FRAC),
        .LANES  (2),
        .SIDE_W (1)
    ) u_uv_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (poly_vld),
        .num       ({nv, nu}),
        .den       ({dv, du}),
        .side_in   (poly_clp),
        .out_valid (uv_vld),
        .quo       (uv),
        .side_out  (uv_clp)
    );

    // matrix and largest component
    logic                  mtx_vld;
    logic [2:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]      max_mag;
    logic signed [63:0]    max_val;
    bbt_side_t             mtx_side;

    bbt_mtx u_mtx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (uv_vld),
        .u         (uv[0]),
        .v         (uv[1]),
        .clamped   (uv_clp),
        .out_valid (mtx_vld),
        .mag       (mag),
        .max_mag   (max_mag),
        .max_val   (max_val),
        .side      (mtx_side)
    );

    // |c| / max with one extra bit for rounding
    logic               nrm_vld;
    logic [2:0][QN-1:0] nq;
    bbt_side_t          nrm_side;

    bbt_div #(
        .W      (MAG_W),
        .QB     (QN),
        .LANES  (3),
        .SIDE_W ($bits(bbt_side_t))
    ) u_nrm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (mtx_vld),
        .num       (mag),
        .den       ({max_mag, max_mag, max_mag}),
        .side_in   (mtx_side),
        .out_valid (nrm_vld),
        .quo       (nq),
        .side_out  (nrm_side)
    );

    // round half away from zero, apply sign, mask to field width
    logic [2:0][OUT_W-1:0] rgb_reg, rgb_next;
    logic                  clp_reg;
    logic                  vld_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [QN:0]  rnd;
            logic [63:0]  ext;
            rnd = ({1'b0, nq[j]} + (QN+1)'(1)) >> 1;
            ext = 64'(rnd);
            if (nrm_side.neg[j]) begin
                ext = -ext;
            end
            rgb_next[j] = nrm_side.zero ? '0 : ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= nrm_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rgb_reg <= rgb_next;
            clp_reg <= nrm_side.clamped;
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = {2'b00, rgb_reg[2], rgb_reg[1], rgb_reg[0]};
    assign m_axis_tuser  = clp_reg;

    // the largest component always normalizes to exactly one
    a_one_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (rgb_reg[0] == OUT_ONE) || (rgb_reg[1] == OUT_ONE)
                       || (rgb_reg[2] == OUT_ONE))
        else $error("no component equals one");

    // in the clamped range the largest component is positive
    a_max_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        mtx_vld |-> (max_val > 64'sd0) && !mtx_side.zero)
        else $error("largest component not positive");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

// ===== bench/blackbody_temperature_to_rgb_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blackbody_temperature_to_rgb_top_tb
// Self-checking bench for the color temperature to RGB pipeline.
// ----------------------------------------------------------------------------
// Sends temperatures over the input stream and predicts each RGB triple with
// an integer model of the locus fit, sRGB matrix and max normalization. Each
// output beat is checked field by field against the oldest prediction. Both
// stream sides idle at random, with bursts of back-to-back traffic too.
// ----------------------------------------------------------------------------
module blackbody_temperature_to_rgb_top_tb;
    import bbt_pkg::*;

    localparam int FRAC       = OUT_FRAC_BITS_DEF;
    localparam int LATENCY    = 3 + 32 + 4 + (FRAC + 1) + 1;
    localparam int IDLE_LIMIT = 20000;   // cycles without any beat
    localparam int RAND_ITEMS = 650;

    typedef struct {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic             clamped;
    } rgb_t;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    rgb_t pending_rgb[$];
    int   mismatches;
    int   beats_in;
    int   beats_out;
    int   clamped_seen;
    int   idle_cycles;
    bit   no_stall;       // forces m_axis_tready high for a burst test
    int   out_stall;

    blackbody_temperature_to_rgb_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] temperature_k
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [17:0] red, [35:18] green, [53:36] blue
        .m_axis_tuser  (m_axis_tuser)    // [0] clamped
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    // Bit-serial fraction num/den, saturating when the quotient reaches 1.
    function automatic longint unsigned quot_bits(longint unsigned num,
                                                  longint unsigned den, int bits);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = num;
        if (den == 0) return 0;
        if (num >= den) return (64'd1 << bits) - 1;
        for (int i = 0; i < bits; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        return q;
    endfunction

    // c / peak, rounded half away from zero, saturating at +-1.0.
    function automatic logic [OUT_W-1:0] scale_by_peak(longint c, longint peak);
        longint unsigned mag;
        longint unsigned uc;
        bit neg;
        neg = c < 0;
        uc  = neg ? -c : c;
        if (uc >= longint'(peak)) mag = 64'd1 << FRAC;
        else mag = (quot_bits(uc, peak, FRAC + 1) + 1) >> 1;
        if (neg) mag = -mag;
        return mag[OUT_W-1:0];
    endfunction

    function automatic rgb_t locus_rgb(logic [TEMP_W-1:0] temp);
        rgb_t res;
        longint unsigned t, tt, nu, du, nv, dv, u, v;
        longint a, b, c, r, g, bl, peak;
        t = temp;
        res.clamped = 1'b0;
        if (temp < T_MIN) begin
            t = T_MIN;
            res.clamped = 1'b1;
        end else if (temp > T_MAX) begin
            t = T_MAX;
            res.clamped = 1'b1;
        end
        tt = t * t;
        nu = C_NU0 + C_NU1 * t + C_NU2 * tt;
        du = C_DU0 + C_DU1 * t + C_DU2 * tt;
        nv = C_NV0 + C_NV1 * t + C_NV2 * tt;
        dv = C_DV0 + C_DV2 * tt - C_DV1 * t;
        u  = quot_bits(nu, du, UV_FRAC);
        v  = quot_bits(nv, dv, UV_FRAC);
        a  = 3 * longint'(u);
        b  = 2 * longint'(v);
        c  = (longint'(4) <<< UV_FRAC) - longint'(u) - 10 * longint'(v);
        r  = 32404542 * a - 15371385 * b - 4985314 * c;
        g  = -9692660 * a + 18760108 * b + 415560 * c;
        bl = 556434 * a - 2040259 * b + 10572252 * c;
        peak = r;
        if (g > peak) peak = g;
        if (bl > peak) peak = bl;
        if (peak <= 0) begin
            res.red = '0; res.green = '0; res.blue = '0;
        end else begin
            res.red   = scale_by_peak(r, peak);
            res.green = scale_by_peak(g, peak);
            res.blue  = scale_by_peak(bl, peak);
        end
        return res;
    endfunction

    // ---------------- output side ----------------

    // Random back-pressure: mostly short stalls, now and then a long one.
    always @(posedge aclk) begin
        if (!aresetn || no_stall) begin
            m_axis_tready <= 1'b1;
            out_stall     <= 0;
        end else if (out_stall > 0) begin
            m_axis_tready <= 1'b0;
            out_stall     <= out_stall - 1;
        end else if ($urandom_range(99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            out_stall     <= ($urandom_range(9) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(3);
        end
    end

    // Result checker: compare every output beat with the oldest prediction.
    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (pending_rgb.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output beat tdata=%h", $realtime,
                             m_axis_tdata);
            end else begin
                want = pending_rgb.pop_front();
                if (m_axis_tdata[17:0] !== want.red ||
                    m_axis_tdata[35:18] !== want.green ||
                    m_axis_tdata[53:36] !== want.blue ||
                    m_axis_tuser !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp %h %h %h %b got %h %h %h %b",
                                 $realtime, want.red, want.green, want.blue, want.clamped,
                                 m_axis_tdata[17:0], m_axis_tdata[35:18],
                                 m_axis_tdata[53:36], m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- input side ----------------

    // One temperature beat; gap is the idle time before it.
    task automatic send_temp(logic [TEMP_W-1:0] temp, int gap);
        rgb_t want;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= temp;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        want = locus_rgb(temp);
        pending_rgb.push_back(want);
        beats_in++;
        if (want.clamped) clamped_seen++;
    endtask

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 93) return $urandom_range(3, 1);
        return $urandom_range(50, 10);
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge aclk);
    endtask

    task automatic test_edges();
        logic [TEMP_W-1:0] temps[$] = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001,
            16'd1500, 16'd2700, 16'd4000, 16'd6500, 16'd6504, 16'd10000, 16'd14999,
            16'd15000, 16'd15001, 16'd32768, 16'd65534, 16'd65535, 16'h5555,
            16'hAAAA};
        foreach (temps[i]) send_temp(temps[i], rand_gap());
        drain();
    endtask

    // Back-to-back input with the output never stalled.
    task automatic test_full_rate();
        no_stall = 1'b1;
        for (int i = 0; i < 80; i++)
            send_temp(TEMP_W'($urandom_range(15000, 1000)), 0);
        drain();
        no_stall = 1'b0;
    endtask

    // Random temperatures, mostly in range, some below 1000, the rest anywhere in 16 bits.
    task automatic test_random();
        int pick;
        logic [TEMP_W-1:0] temp;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 75) temp = TEMP_W'($urandom_range(15000, 1000));
            else if (pick < 85) temp = TEMP_W'($urandom_range(999));
            else temp = TEMP_W'($urandom_range(65535));
            send_temp(temp, rand_gap());
            if (i == RAND_ITEMS / 2) drain();   // sender holds until all results in
        end
        drain();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        no_stall      = 1'b0;
        out_stall     = 0;
        idle_cycles   = 0;
        mismatches    = 0;
        beats_in      = 0;
        beats_out     = 0;
        clamped_seen  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edges();
        test_full_rate();
        test_random();

        repeat (LATENCY + 10) @(posedge aclk);
        if (pending_rgb.size() != 0) mismatches++;
        $display("Sent %0d temperatures (%0d out of range), checked %0d RGB results.",
                 beats_in, clamped_seen, beats_out);
        $display("Stalls on both streams, a full-rate burst and a drain pause included.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
